// ===== rtl/rfa_pkg.sv =====
// package: payload types and datapath command/status types for the fraction alu
package rfa_pkg;

  localparam int IO_W = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [IO_W-1:0] a_num;
    logic signed [IO_W-1:0] a_den;
    logic signed [IO_W-1:0] b_num;
    logic signed [IO_W-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [IO_W-1:0] res_num;
    logic signed [IO_W-1:0] res_den;
    logic                   div_by_zero;
    logic                   overflow;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // capture operands, fix zero denominators
    OP_SEL_A,    // x,y <- a_num, a_den
    OP_SEL_B,    // x,y <- b_num, b_den
    OP_SEL_R,    // x,y <- r_num, r_den (zero den -> 1)
    OP_REM_GO,   // start remainder x % y
    OP_REM_END,  // x <- y, y <- rem
    OP_Q1_GO,    // start num / gcd
    OP_Q1_END,
    OP_Q2_GO,    // start den / gcd
    OP_Q2_END,
    OP_MUL1,     // first product pair step
    OP_MUL2,
    OP_MUL3,     // denominator product
    OP_COMB      // combine
  } dp_op_t;

  typedef enum logic [1:0] {
    DST_A,
    DST_B,
    DST_R
  } dst_t;

  typedef struct packed {
    dp_op_t op;
    dst_t   dst;
  } dp_cmd_t;

  typedef struct packed {
    logic y_zero;    // euclid done
    logic g_zero;    // gcd came out zero
    logic div_done;  // divider finished
    logic bn_zero;   // b numerator zero after reduction
    logic is_div;
  } dp_stat_t;

endpackage

// ===== rtl/rfa_div.sv =====
// shared iterative divider: truncated signed quotient and remainder, one bit a cycle
module rfa_div import rfa_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dvd,
  input  logic [W-1:0] dvs,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt, d_r, d_nxt;
  logic [W:0]    p_r, p_nxt;
  logic          qn_r, qn_nxt, rn_r, rn_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial, shifted;

  assign shifted = {p_r[W-1:0], q_r[W-1]};
  assign trial   = shifted - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    p_nxt    = p_r;
    qn_nxt   = qn_r;
    rn_nxt   = rn_r;
    done_nxt = 1'b0;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      q_nxt    = dvd[W-1] ? (~dvd + 1'b1) : dvd;
      d_nxt    = dvs[W-1] ? (~dvs + 1'b1) : dvs;
      p_nxt    = '0;
      qn_nxt   = dvd[W-1] ^ dvs[W-1];
      rn_nxt   = dvd[W-1];
    end else if (busy_r) begin
      if (!trial[W]) begin
        p_nxt = trial;
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        p_nxt = shifted;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r  <= q_nxt;
    d_r  <= d_nxt;
    p_r  <= p_nxt;
    qn_r <= qn_nxt;
    rn_r <= rn_nxt;
  end

  assign done = done_r;
  assign quo  = qn_r ? (~q_r + 1'b1) : q_r;
  assign rem  = rn_r ? (~p_r[W-1:0] + 1'b1) : p_r[W-1:0];
endmodule

// ===== rtl/rfa_datapath.sv =====
// datapath: operand registers, euclid registers, multiplier and shared divider
module rfa_datapath import rfa_pkg::*; #(
  parameter int W = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t result
);
  logic [W-1:0] an_r, ad_r, bn_r, bd_r, rn_r, rd_r;
  logic [W-1:0] x_r, y_r, g_r;
  logic [1:0]   kind_r;
  logic         ovf_r, dz_r;
  logic [W-1:0] m1_r, m2_r, m3_r;
  logic         o1_r, o2_r, o3_r;
  logic [W-1:0] ma, mb;
  logic [2*W-1:0] prod;
  logic         mo;
  logic         div_go, div_done;
  logic [W-1:0] div_a, div_b, quo, rem;

  function automatic logic [W-1:0] ext(input logic [IO_W-1:0] v);
    logic [63:0] s;
    s = {{(64-IO_W){v[IO_W-1]}}, v};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fix_den(input logic [W-1:0] v);
    return (v == '0) ? W'(1) : v;
  endfunction

  // one signed multiply a cycle, overflow from the full product
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MUL1: begin
        ma = an_r;
        mb = (kind_r == KIND_DIV) ? bd_r : ((kind_r == KIND_MUL) ? bn_r : bd_r);
      end
      OP_MUL2: begin
        ma = (kind_r == KIND_MUL || kind_r == KIND_DIV) ? ad_r : bn_r;
        mb = (kind_r == KIND_MUL) ? bd_r : ((kind_r == KIND_DIV) ? bn_r : ad_r);
      end
      OP_MUL3: begin
        ma = ad_r;
        mb = bd_r;
      end
      default: ;
    endcase
  end

  assign prod = $signed(ma) * $signed(mb);
  assign mo   = (prod[2*W-1:W-1] != {(W+1){1'b0}}) && (prod[2*W-1:W-1] != {(W+1){1'b1}});

  always_comb begin
    div_go = 1'b0;
    div_a  = x_r;
    div_b  = y_r;
    unique case (cmd.op)
      OP_REM_GO: div_go = 1'b1;
      OP_Q1_GO: begin
        div_go = 1'b1;
        div_a  = (cmd.dst == DST_A) ? an_r : ((cmd.dst == DST_B) ? bn_r : rn_r);
        div_b  = g_r;
      end
      OP_Q2_GO: begin
        div_go = 1'b1;
        div_a  = (cmd.dst == DST_A) ? ad_r : ((cmd.dst == DST_B) ? bd_r : rd_r);
        div_b  = g_r;
      end
      default: ;
    endcase
  end

  rfa_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dvd(div_a), .dvs(div_b),
    .done(div_done), .quo(quo), .rem(rem)
  );

  logic [W-1:0] s_add, s_sub;
  logic         oa, os;
  assign s_add = m1_r + m2_r;
  assign s_sub = m1_r - m2_r;
  assign oa = (m1_r[W-1] == m2_r[W-1]) && (s_add[W-1] != m1_r[W-1]);
  assign os = (m1_r[W-1] != m2_r[W-1]) && (s_sub[W-1] != m1_r[W-1]);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind_r <= in_item.kind;
        an_r   <= ext(in_item.a_num);
        ad_r   <= fix_den(ext(in_item.a_den));
        bn_r   <= ext(in_item.b_num);
        bd_r   <= fix_den(ext(in_item.b_den));
        ovf_r  <= 1'b0;
        dz_r   <= 1'b0;
      end
      OP_SEL_A: begin x_r <= an_r; y_r <= ad_r; end
      OP_SEL_B: begin x_r <= bn_r; y_r <= bd_r; end
      OP_SEL_R: begin x_r <= rn_r; y_r <= fix_den(rd_r); rd_r <= fix_den(rd_r); end
      OP_REM_GO: g_r <= g_r;
      OP_REM_END: begin x_r <= y_r; y_r <= rem; g_r <= y_r; end
      OP_Q1_END: begin
        unique case (cmd.dst)
          DST_A:   an_r <= quo;
          DST_B:   bn_r <= quo;
          default: rn_r <= quo;
        endcase
      end
      OP_Q2_END: begin
        unique case (cmd.dst)
          DST_A:   ad_r <= quo;
          DST_B:   bd_r <= quo;
          default: rd_r <= quo;
        endcase
      end
      OP_MUL1: begin m1_r <= prod[W-1:0]; o1_r <= mo; end
      OP_MUL2: begin m2_r <= prod[W-1:0]; o2_r <= mo; end
      OP_MUL3: begin m3_r <= prod[W-1:0]; o3_r <= mo; end
      OP_COMB: begin
        // combine after the products settle
        if (kind_r == KIND_DIV && bn_r == '0) begin
          rn_r <= an_r;
          rd_r <= ad_r;
          dz_r <= 1'b1;
        end else begin
          unique case (kind_r)
            KIND_ADD: begin rn_r <= s_add; rd_r <= m3_r; ovf_r <= o1_r | o2_r | o3_r | oa; end
            KIND_SUB: begin rn_r <= s_sub; rd_r <= m3_r; ovf_r <= o1_r | o2_r | o3_r | os; end
            default:  begin rn_r <= m1_r;  rd_r <= m2_r; ovf_r <= o1_r | o2_r; end
          endcase
        end
      end
      default: ;
    endcase
    // gcd of x and zero y is x itself
    if (cmd.op == OP_SEL_A || cmd.op == OP_SEL_B || cmd.op == OP_SEL_R) g_r <= '0;
  end

  // gcd is x once y reaches zero
  logic [W-1:0] gcur;
  assign gcur = x_r;

  assign stat.y_zero   = (y_r == '0);
  assign stat.g_zero   = (gcur == '0);
  assign stat.div_done = div_done;
  assign stat.bn_zero  = (bn_r == '0);
  assign stat.is_div   = (kind_r == KIND_DIV);

  assign result.res_num     = IO_W'(rn_r);
  assign result.res_den     = IO_W'(rd_r);
  assign result.div_by_zero = dz_r;
  assign result.overflow    = ovf_r;
endmodule

// ===== rtl/rfa_ctrl.sv =====
// controller: sequences normalizing, cross products and final reduction
module rfa_ctrl import rfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd,
  output logic     out_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_SEL, S_CHK, S_REM, S_REMW, S_Q1, S_Q1W, S_Q2, S_Q2W,
    S_M1, S_M2, S_M3, S_COMB, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  dst_t   dst_r, dst_nxt;
  logic   vld_r, vld_nxt;

  always_comb begin
    state_nxt = state_r;
    dst_nxt   = dst_r;
    vld_nxt   = 1'b0;
    cmd.op    = OP_NONE;
    cmd.dst   = dst_r;
    unique case (state_r)
      S_IDLE: begin
        // operands captured at the accepting edge
        if (start) begin
          cmd.op = OP_LOAD; dst_nxt = DST_A; state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        unique case (dst_r)
          DST_A:   cmd.op = OP_SEL_A;
          DST_B:   cmd.op = OP_SEL_B;
          default: cmd.op = OP_SEL_R;
        endcase
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // x holds the gcd once y is zero
        if (stat.y_zero) state_nxt = stat.g_zero ? S_Q2W : S_Q1;
        else state_nxt = S_REM;
      end
      S_REM: begin cmd.op = OP_REM_GO; state_nxt = S_REMW; end
      S_REMW: if (stat.div_done) begin cmd.op = OP_REM_END; state_nxt = S_CHK; end
      S_Q1: begin cmd.op = OP_Q1_GO; state_nxt = S_Q1W; end
      S_Q1W: if (stat.div_done) begin cmd.op = OP_Q1_END; state_nxt = S_Q2; end
      S_Q2: begin cmd.op = OP_Q2_GO; state_nxt = S_Q2W; end
      S_Q2W: begin
        if (stat.div_done || stat.g_zero) begin
          if (stat.div_done) cmd.op = OP_Q2_END;
          unique case (dst_r)
            DST_A:   begin dst_nxt = DST_B; state_nxt = S_SEL; end
            DST_B:   state_nxt = S_M1;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_M1: begin cmd.op = OP_MUL1; state_nxt = S_M2; end
      S_M2: begin cmd.op = OP_MUL2; state_nxt = S_M3; end
      S_M3: begin cmd.op = OP_MUL3; state_nxt = S_COMB; end
      S_COMB: begin
        cmd.op = OP_COMB; cmd.dst = DST_R; dst_nxt = DST_R; state_nxt = S_SEL;
      end
      S_DONE: begin vld_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dst_r   <= DST_A;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dst_r   <= dst_nxt;
      vld_r   <= vld_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = vld_r;
endmodule

// ===== rtl/rational_fraction_alu_top.sv =====
// top level: rational fraction alu with gcd reduction
// the time from acceptance to out_valid grows with the euclid remainder steps over the three
//   reductions (at least three); each remainder step and each quotient runs on the shared bit-serial divider
// throughput: one item at a time; the next beat can be accepted in the out_valid cycle
// busy is high from acceptance until out_valid; the receiver cannot stall
// synchronous active-low reset returns the controller to idle
module rational_fraction_alu_top import rfa_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  rfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
    .busy(busy), .cmd(cmd), .out_valid(out_valid)
  );

  // operand, euclid and product registers
  rfa_datapath #(.W(WORD_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
    .stat(stat), .result(out_item)
  );
endmodule

// ===== rtl/rfa_checker.sv =====
// checker: port-level properties of the fraction alu, bound to the top level
module rfa_checker import rfa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.div_by_zero && out_item.overflow))
    else $error("both flags set");
endmodule

bind rational_fraction_alu_top rfa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
